/* rtl/chb_pkg.sv */
// chb_pkg: shared types, character codes and helpers for the chunked body decoder
// no dependencies; used by chb_cfg, chb_core and http_chunked_body_decoder
`default_nettype none

package chb_pkg;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned MAX_BODY_W = 24;
	localparam logic [MAX_BODY_W-1:0] MAX_BODY_RESET = 24'd1048576;
	localparam logic [0:0] REG_MAX_BODY = 1'b0;

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_HT = 8'h09;
	localparam logic [7:0] EXT_MARK = 8'h3b;
	localparam int unsigned SKIP_COUNT = 2;

	typedef enum logic [2:0] {
		KIND_FRAME = 3'd0,
		KIND_DATA  = 3'd1,
		KIND_DONE  = 3'd2,
		KIND_BAD   = 3'd3,
		KIND_BIG   = 3'd4,
		KIND_AFTER = 3'd5
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} result_t;

	// bit 4 set when the byte is a hex digit, low nibble its value
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/chb_cfg.sv */
// chb_cfg: apb register holding the body size limit, capped to the length width
// depends on chb_pkg
`default_nettype none

module chb_cfg #(
	parameter int unsigned LENGTH_BITS = 24
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [chb_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [chb_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [chb_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                pready,
	output logic      [LENGTH_BITS-1:0]         limit
);

	localparam int unsigned WIDE_W = 41;
	localparam logic [WIDE_W-1:0] LEN_MAX = (WIDE_W'(1) << LENGTH_BITS) - WIDE_W'(1);

	logic [chb_pkg::MAX_BODY_W-1:0] max_body_q;
	logic                           sel_max;
	logic [WIDE_W-1:0]              wide;

	assign pready  = 1'b1;
	assign sel_max = (paddr[chb_pkg::CFG_ADDR_W-1] == chb_pkg::REG_MAX_BODY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_q <= chb_pkg::MAX_BODY_RESET;
		end else if (psel && penable && pwrite && sel_max) begin
			max_body_q <= pwdata[chb_pkg::MAX_BODY_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_max) begin
			prdata = chb_pkg::CFG_DATA_W'(max_body_q);
		end
	end

	always_comb begin
		wide = WIDE_W'(max_body_q);
		if (wide > LEN_MAX) begin
			limit = '1;
		end else begin
			limit = wide[LENGTH_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/chb_core.sv */
// chb_core: decoder state and the per-byte next-state and result logic
// depends on chb_pkg
`default_nettype none

module chb_core #(
	parameter int unsigned LENGTH_BITS = 24
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire logic [7:0]             byte_in,
	input  wire logic                   restart_in,
	input  wire logic [LENGTH_BITS-1:0] limit,
	output chb_pkg::result_t            res
);

	typedef enum logic [2:0] {
		PH_LEAD    = 3'd0,
		PH_HEX     = 3'd1,
		PH_EXT     = 3'd2,
		PH_DATA    = 3'd3,
		PH_SKIP    = 3'd4,
		PH_TRAILER = 3'd5,
		PH_END     = 3'd6
	} phase_t;

	localparam int unsigned LB = LENGTH_BITS;

	phase_t           phase_q, ph, ph_n;
	logic [LB-1:0]    chunk_left_q, cl, cl_n, cl_dec;
	logic [LB-1:0]    size_accum_q, sa, sa_n;
	logic [LB:0]      body_total_q, bt, bt_n;
	logic             tbs_q, tbs, tbs_n;
	logic             pcr_q, pcr, pcr_n;
	logic             lne_q, lne, lne_n;

	logic [4:0]       hv;
	logic             blank;
	logic             rest, do_eol, do_digit, do_stop;
	chb_pkg::kind_t   stop_kind;
	logic [LB+3:0]    acc;
	logic [LB+1:0]    total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LEAD;
			chunk_left_q <= '0;
			size_accum_q <= '0;
			body_total_q <= '0;
			tbs_q        <= 1'b0;
			pcr_q        <= 1'b0;
			lne_q        <= 1'b0;
		end else if (step) begin
			phase_q      <= ph_n;
			chunk_left_q <= cl_n;
			size_accum_q <= sa_n;
			body_total_q <= bt_n;
			tbs_q        <= tbs_n;
			pcr_q        <= pcr_n;
			lne_q        <= lne_n;
		end
	end

	// restart clears state ahead of this byte
	always_comb begin
		if (restart_in) begin
			ph  = PH_LEAD;
			cl  = '0;
			sa  = '0;
			bt  = '0;
			tbs = 1'b0;
			pcr = 1'b0;
			lne = 1'b0;
		end else begin
			ph  = phase_q;
			cl  = chunk_left_q;
			sa  = size_accum_q;
			bt  = body_total_q;
			tbs = tbs_q;
			pcr = pcr_q;
			lne = lne_q;
		end
	end

	assign hv     = chb_pkg::hex_value(byte_in);
	assign blank  = (byte_in == chb_pkg::CH_SP) || (byte_in == chb_pkg::CH_HT);
	assign acc    = {sa, 4'b0000} + (LB+4)'(hv[3:0]);
	assign total  = (LB+2)'(bt) + (LB+2)'(sa);
	assign cl_dec = cl - LB'(1);

	always_comb begin
		ph_n      = ph;
		cl_n      = cl;
		sa_n      = sa;
		bt_n      = bt;
		tbs_n     = tbs;
		pcr_n     = pcr;
		lne_n     = lne;
		res.data  = 8'd0;
		res.kind  = chb_pkg::KIND_FRAME;
		res.last  = 1'b0;
		rest      = 1'b0;
		do_eol    = 1'b0;
		do_digit  = 1'b0;
		do_stop   = 1'b0;
		stop_kind = chb_pkg::KIND_BAD;

		case (ph)
			PH_DATA: begin
				res.data = byte_in;
				res.kind = chb_pkg::KIND_DATA;
				cl_n     = cl_dec;
				if (cl_dec == '0) begin
					res.last = 1'b1;
					ph_n     = PH_SKIP;
					cl_n     = LB'(chb_pkg::SKIP_COUNT);
				end
			end
			PH_SKIP: begin
				cl_n = cl_dec;
				if (cl_dec == '0) begin
					ph_n  = PH_LEAD;
					cl_n  = '0;
					sa_n  = '0;
					tbs_n = 1'b0;
					pcr_n = 1'b0;
					lne_n = 1'b0;
				end
			end
			PH_LEAD, PH_HEX, PH_EXT, PH_TRAILER: begin
				if (pcr) begin
					pcr_n = 1'b0;
					if (byte_in == chb_pkg::CH_LF) begin
						do_eol = 1'b1;
					end else if (ph == PH_LEAD || ph == PH_HEX) begin
						do_stop = 1'b1;
					end else begin
						if (ph == PH_TRAILER) begin
							lne_n = 1'b1;
						end
						rest = 1'b1;
					end
				end else begin
					rest = 1'b1;
				end
				if (rest) begin
					if (byte_in == chb_pkg::CH_CR) begin
						pcr_n = 1'b1;
					end else if (byte_in == chb_pkg::CH_LF) begin
						do_eol = 1'b1;
					end else if (ph == PH_TRAILER) begin
						lne_n = 1'b1;
					end else if (ph == PH_EXT) begin
						ph_n = PH_EXT;
					end else if (byte_in == chb_pkg::EXT_MARK) begin
						ph_n = PH_EXT;
					end else if (ph == PH_LEAD) begin
						if (hv[4]) begin
							do_digit = 1'b1;
						end else if (!blank) begin
							do_stop = 1'b1;
						end
					end else begin
						if (blank) begin
							tbs_n = 1'b1;
						end else if (hv[4] && !tbs) begin
							do_digit = 1'b1;
						end else begin
							do_stop = 1'b1;
						end
					end
				end
				if (do_digit) begin
					if (acc > (LB+4)'(limit)) begin
						do_stop   = 1'b1;
						stop_kind = chb_pkg::KIND_BIG;
					end else begin
						sa_n  = acc[LB-1:0];
						lne_n = 1'b1;
						ph_n  = PH_HEX;
					end
				end
				if (do_eol) begin
					if (ph == PH_TRAILER) begin
						if (!lne) begin
							do_stop   = 1'b1;
							stop_kind = chb_pkg::KIND_DONE;
						end else begin
							lne_n = 1'b0;
						end
					end else if (!lne) begin
						do_stop = 1'b1;
					end else if (total > (LB+2)'(limit)) begin
						do_stop   = 1'b1;
						stop_kind = chb_pkg::KIND_BIG;
					end else if (sa == '0) begin
						ph_n  = PH_TRAILER;
						lne_n = 1'b0;
					end else begin
						bt_n = total[LB:0];
						cl_n = sa;
						ph_n = PH_DATA;
					end
				end
				if (do_stop) begin
					ph_n     = PH_END;
					pcr_n    = 1'b0;
					res.kind = stop_kind;
				end
			end
			default: begin
				ph_n     = PH_END;
				res.kind = chb_pkg::KIND_AFTER;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/http_chunked_body_decoder.sv */
// http_chunked_body_decoder: chunked transfer body decoder, one byte per item
// result registered after the input register; one item per cycle unless stalled
// the decoder state loop closes between the input and result registers
// a stalled result is held while one more item waits in the input register
// asynchronous reset clears state to the start of a chunk-size line, limit to 1048576
// depends on chb_pkg, chb_cfg, chb_core
`default_nettype none

module http_chunked_body_decoder #(
	parameter int unsigned LENGTH_BITS = 24
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [7:0]                          in_byte,
	input  wire logic                                restart,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic      [7:0]                          out_byte,
	output logic      [2:0]                          kind,
	output logic                                     last_of_chunk,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [chb_pkg::CFG_ADDR_W-1:0]      paddr,
	input  wire logic [chb_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic      [chb_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                     pready
);

	logic                     valid_s1;
	logic [7:0]               byte_s1;
	logic                     restart_s1;
	logic                     out_valid_q;
	chb_pkg::result_t         res, res_q;
	logic                     out_free;
	logic                     adv;
	logic [LENGTH_BITS-1:0]   limit;

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	chb_cfg #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.limit   (limit)
	);

	chb_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.byte_in    (byte_s1),
		.restart_in (restart_s1),
		.limit      (limit),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1    <= in_byte;
			restart_s1 <= restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = res_q.data;
	assign kind          = res_q.kind;
	assign last_of_chunk = res_q.last;

endmodule

`default_nettype wire

/* bench/tb_http_chunked_body_decoder.sv */
// testbench for http_chunked_body_decoder: directed and random chunked body streams,
// per-byte classification checked against an in-bench decoder model; limit register via apb
// depends on chb_pkg and the decoder rtl
`timescale 1ns / 100ps

module tb_http_chunked_body_decoder;

	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD = 48;
	localparam int SETTLE = 8;
	localparam int PHASES = 8;
	localparam logic [chb_pkg::CFG_ADDR_W-1:0] LIMIT_ADDR =
		chb_pkg::CFG_ADDR_W'(4 * chb_pkg::REG_MAX_BODY);

	typedef enum logic [2:0] {
		SEG_LEAD, SEG_HEX, SEG_EXT, SEG_DATA, SEG_SKIP, SEG_TRAILER, SEG_END
	} segment_t;

	typedef struct {
		logic [7:0] octet;
		logic       restart;
	} byte_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] in_byte = 8'h00;
	logic restart = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_byte;
	logic [2:0] kind;
	logic last_of_chunk;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [chb_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [chb_pkg::CFG_DATA_W-1:0] pwdata = '0;
	logic [chb_pkg::CFG_DATA_W-1:0] prdata;
	logic pready;

	// decoder model state
	segment_t dec_phase = SEG_LEAD;
	logic [23:0] bytes_left = '0;
	logic [23:0] size_so_far = '0;
	logic [24:0] body_so_far = '0;
	logic gap_after_size = 1'b0;
	logic cr_held = 1'b0;
	logic line_has_text = 1'b0;
	logic [23:0] body_limit = chb_pkg::MAX_BODY_RESET;

	byte_item_t byte_items[$];
	byte_item_t next_item;
	chb_pkg::result_t classified_bytes[$];
	chb_pkg::result_t due;
	logic [7:0] message_bytes[$];
	int items_queued = 0;
	int mismatches = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int holds_asked = 0;
	int holds_given = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	http_chunked_body_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.kind(kind),
		.last_of_chunk(last_of_chunk),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	function automatic chb_pkg::kind_t halt_with(input chb_pkg::kind_t k);
		dec_phase = SEG_END;
		cr_held = 1'b0;
		return k;
	endfunction

	function automatic chb_pkg::kind_t push_digit(input int d);
		logic [31:0] acc;
		acc = {4'd0, size_so_far, 4'd0} + 32'(d);
		if (acc > 32'(body_limit)) return halt_with(chb_pkg::KIND_BIG);
		size_so_far = acc[23:0];
		line_has_text = 1'b1;
		dec_phase = SEG_HEX;
		return chb_pkg::KIND_FRAME;
	endfunction

	function automatic chb_pkg::kind_t close_line();
		logic [31:0] total;
		if (dec_phase == SEG_TRAILER) begin
			if (!line_has_text) return halt_with(chb_pkg::KIND_DONE);
			line_has_text = 1'b0;
			return chb_pkg::KIND_FRAME;
		end
		if (!line_has_text) return halt_with(chb_pkg::KIND_BAD);
		total = 32'(body_so_far) + 32'(size_so_far);
		if (total > 32'(body_limit)) return halt_with(chb_pkg::KIND_BIG);
		if (size_so_far == 0) begin
			dec_phase = SEG_TRAILER;
			line_has_text = 1'b0;
			return chb_pkg::KIND_FRAME;
		end
		body_so_far = total[24:0];
		bytes_left = size_so_far;
		dec_phase = SEG_DATA;
		return chb_pkg::KIND_FRAME;
	endfunction

	function automatic chb_pkg::kind_t size_line_char(input logic [7:0] b);
		int d;
		logic blank;
		blank = (b == chb_pkg::CH_SP || b == chb_pkg::CH_HT);
		if (cr_held) begin
			cr_held = 1'b0;
			if (b == chb_pkg::CH_LF) return close_line();
			if (dec_phase == SEG_LEAD || dec_phase == SEG_HEX)
				return halt_with(chb_pkg::KIND_BAD);
			if (dec_phase == SEG_TRAILER) line_has_text = 1'b1;
		end
		if (b == chb_pkg::CH_CR) begin
			cr_held = 1'b1;
			return chb_pkg::KIND_FRAME;
		end
		if (b == chb_pkg::CH_LF) return close_line();
		if (dec_phase == SEG_TRAILER) begin
			line_has_text = 1'b1;
			return chb_pkg::KIND_FRAME;
		end
		if (dec_phase == SEG_EXT) return chb_pkg::KIND_FRAME;
		if (b == chb_pkg::EXT_MARK) begin
			dec_phase = SEG_EXT;
			return chb_pkg::KIND_FRAME;
		end
		if (b >= 8'h30 && b <= 8'h39) d = int'(b) - 'h30;
		else if (b >= 8'h61 && b <= 8'h66) d = int'(b) - 'h57;
		else if (b >= 8'h41 && b <= 8'h46) d = int'(b) - 'h37;
		else d = -1;
		if (dec_phase == SEG_LEAD) begin
			if (blank) return chb_pkg::KIND_FRAME;
			if (d >= 0) return push_digit(d);
			return halt_with(chb_pkg::KIND_BAD);
		end
		if (blank) begin
			gap_after_size = 1'b1;
			return chb_pkg::KIND_FRAME;
		end
		if (d >= 0 && !gap_after_size) return push_digit(d);
		return halt_with(chb_pkg::KIND_BAD);
	endfunction

	function automatic chb_pkg::result_t classify_byte(input logic [7:0] b, input logic rs);
		chb_pkg::result_t r;
		r.data = 8'h00;
		r.kind = chb_pkg::KIND_FRAME;
		r.last = 1'b0;
		if (rs) begin
			dec_phase = SEG_LEAD;
			bytes_left = '0;
			size_so_far = '0;
			body_so_far = '0;
			gap_after_size = 1'b0;
			cr_held = 1'b0;
			line_has_text = 1'b0;
		end
		case (dec_phase)
			SEG_DATA: begin
				r.data = b;
				r.kind = chb_pkg::KIND_DATA;
				bytes_left = bytes_left - 24'd1;
				if (bytes_left == 0) begin
					r.last = 1'b1;
					dec_phase = SEG_SKIP;
					bytes_left = 24'(chb_pkg::SKIP_COUNT);
				end
			end
			SEG_SKIP: begin
				bytes_left = bytes_left - 24'd1;
				if (bytes_left == 0) begin
					dec_phase = SEG_LEAD;
					size_so_far = '0;
					gap_after_size = 1'b0;
					cr_held = 1'b0;
					line_has_text = 1'b0;
				end
			end
			SEG_LEAD, SEG_HEX, SEG_EXT, SEG_TRAILER: r.kind = size_line_char(b);
			default: begin
				dec_phase = SEG_END;
				r.kind = chb_pkg::KIND_AFTER;
			end
		endcase
		return r;
	endfunction

	task automatic add_byte(input logic [7:0] b, input logic rs);
		byte_items.push_back('{octet: b, restart: rs});
		items_queued++;
	endtask

	task automatic add_text(input string s, input logic rs);
		for (int i = 0; i < s.len(); i++) add_byte(s[i], rs && i == 0);
	endtask

	task automatic end_line();
		if ($urandom_range(0, 1)) message_bytes.push_back(chb_pkg::CH_CR);
		message_bytes.push_back(chb_pkg::CH_LF);
	endtask

	task automatic queue_message();
		int chunks;
		int size;
		int pick;
		int cut;
		string digits;
		logic [7:0] ch;
		message_bytes.delete();
		chunks = $urandom_range(0, 4);
		for (int c = 0; c <= chunks; c++) begin
			pick = $urandom_range(0, 19);
			if (c == chunks) size = 0;
			else if (pick < 13) size = $urandom_range(1, 8);
			else if (pick < 17) size = $urandom_range(9, 64);
			else if (pick < 19) size = $urandom_range(65, 300);
			else size = $urandom_range(1, 28'hFFFFFFF);
			if ($urandom_range(0, 3) == 0)
				message_bytes.push_back($urandom_range(0, 1) ? chb_pkg::CH_SP : chb_pkg::CH_HT);
			digits = $sformatf("%0h", size);
			if ($urandom_range(0, 4) == 0) digits = {"0", digits};
			for (int i = 0; i < digits.len(); i++) begin
				ch = digits[i];
				if (ch >= 8'h61 && $urandom_range(0, 1)) ch = ch - 8'h20;
				message_bytes.push_back(ch);
			end
			if ($urandom_range(0, 3) == 0)
				message_bytes.push_back($urandom_range(0, 1) ? chb_pkg::CH_SP : chb_pkg::CH_HT);
			if ($urandom_range(0, 3) == 0) begin
				message_bytes.push_back(chb_pkg::EXT_MARK);
				repeat ($urandom_range(0, 5))
					message_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
				if ($urandom_range(0, 5) == 0) begin
					message_bytes.push_back(chb_pkg::CH_CR);
					message_bytes.push_back(8'h78);
				end
			end
			end_line();
			// huge sizes only exercise the limit; stop the message there
			if (size > 300) break;
			if (size == 0) begin
				repeat ($urandom_range(0, 2)) begin
					if ($urandom_range(0, 5) == 0) message_bytes.push_back(chb_pkg::CH_CR);
					repeat ($urandom_range(1, 6))
						message_bytes.push_back(8'($urandom_range(8'h21, 8'h7e)));
					end_line();
				end
				end_line();
			end else begin
				repeat (size) message_bytes.push_back(8'($urandom));
				if ($urandom_range(0, 4) == 0) begin
					repeat (2) message_bytes.push_back(8'($urandom));
				end else begin
					message_bytes.push_back(chb_pkg::CH_CR);
					message_bytes.push_back(chb_pkg::CH_LF);
				end
			end
		end
		// occasional damage: one byte replaced, cut short, or trailing noise
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			message_bytes[$urandom_range(0, message_bytes.size() - 1)] = 8'($urandom);
		end else if (pick == 1) begin
			cut = $urandom_range(0, message_bytes.size());
			while (message_bytes.size() > cut) void'(message_bytes.pop_back());
		end else if (pick == 2) begin
			repeat ($urandom_range(1, 4)) message_bytes.push_back(8'($urandom));
		end
		foreach (message_bytes[i])
			add_byte(message_bytes[i],
				i == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 199) == 0));
	endtask

	task automatic write_limit(input logic [23:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= chb_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		body_limit = value;
	endtask

	task automatic check_limit_reg();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= LIMIT_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[chb_pkg::MAX_BODY_W-1:0] !== body_limit) begin
			$display("%0t: max_body_bytes read expected %0d got %0d", $time, body_limit,
				prdata[chb_pkg::MAX_BODY_W-1:0]);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) classified_bytes.push_back(classify_byte(in_byte, restart));
			if (!in_valid || !in_stall) begin
				if (byte_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					next_item = byte_items.pop_front();
					in_valid <= 1'b1;
					in_byte <= next_item.octet;
					restart <= next_item.restart;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (classified_bytes.size() == 0) begin
				$display("%0t: unexpected item, kind %0d out_byte %02h", $time, kind, out_byte);
				mismatches++;
			end else begin
				due = classified_bytes.pop_front();
				if (kind !== due.kind) begin
					$display("%0t: kind expected %0d got %0d", $time, due.kind, kind);
					mismatches++;
				end
				if (out_byte !== due.data) begin
					$display("%0t: out_byte expected %02h got %02h", $time, due.data, out_byte);
					mismatches++;
				end
				if (last_of_chunk !== due.last) begin
					$display("%0t: last_of_chunk expected %0b got %0b", $time, due.last,
						last_of_chunk);
					mismatches++;
				end
			end
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_given != holds_asked) begin
			holds_given <= holds_asked;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int phase_end;
		logic [23:0] limit_now;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			sender_idle_pct = 0;
			receiver_stall_pct = 0;
			check_limit_reg();
			case (p)
				0: limit_now = chb_pkg::MAX_BODY_RESET;
				1: limit_now = 24'hFFFFFF;
				2: limit_now = 24'd1;
				3: limit_now = 24'd300;
				4: limit_now = 24'd40;
				5: limit_now = 24'd4096;
				6: limit_now = 24'($urandom_range(1, 24'hFFFFFF));
				default: limit_now = 24'hFFFFFF;
			endcase
			write_limit(limit_now);
			check_limit_reg();
			case (p % 4)
				1: sender_idle_pct = 57;
				2: receiver_stall_pct = 57;
				3: begin
					sender_idle_pct = 30;
					receiver_stall_pct = 30;
				end
				default: ;
			endcase
			if (p == 0) begin
				// stray cr in an extension and a trailer, data byte ff, 00 and 80 skipped as the chunk's crlf, after end
				add_text("1;\015z\015\012", 1'b1);
				add_byte(8'hFF, 1'b0);
				add_byte(8'h00, 1'b0);
				add_byte(8'h80, 1'b0);
				add_text("0\012\015q\012\012A", 1'b0);
				// blank inside the size, stray cr in the size, no digits, oversize digit
				add_text(" 1\0112", 1'b1);
				add_text("\0151", 1'b1);
				add_text("\012", 1'b1);
				add_text("fFFFFF", 1'b1);
			end
			phase_end = (p + 1) * 110;
			do queue_message(); while (items_queued < phase_end);
			if (p == 0) holds_asked++;
			while (byte_items.size() != 0 || in_valid || classified_bytes.size() != 0)
				@(posedge clk);
			repeat (SETTLE) @(posedge clk);
		end
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
